// ===== rtl/sv32ptw_pkg.sv =====
// ----------------------------------------------------------------------------
// sv32ptw_pkg
// shared types and codes for the sv32 page table walker
// ----------------------------------------------------------------------------
`default_nettype none

package sv32ptw_pkg;

    // input item operations
    localparam logic OP_TRANSLATE = 1'b0;
    localparam logic OP_RESPONSE  = 1'b1;

    // access types
    localparam logic [1:0] ACC_FETCH = 2'd0;
    localparam logic [1:0] ACC_LOAD  = 2'd1;
    localparam logic [1:0] ACC_STORE = 2'd2;

    // privilege levels
    localparam logic [1:0] PRIV_USER    = 2'd0;
    localparam logic [1:0] PRIV_SUPER   = 2'd1;
    localparam logic [1:0] PRIV_MACHINE = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_READ      = 2'd0;
    localparam logic [1:0] KIND_WRITEBACK = 2'd1;
    localparam logic [1:0] KIND_DONE      = 2'd2;

    // fault codes: page fault is access type + 1, access fault three above
    localparam logic [2:0] FAULT_NONE          = 3'd0;
    localparam logic [2:0] FAULT_PAGE_BASE     = 3'd1;
    localparam logic [2:0] ACCESS_FAULT_OFFSET = 3'd3;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRANSLATE_ENABLE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROOT_TABLE_PAGE   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALLOW_USER_ACCESS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXEC_IMPLIES_READ = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAULT_ON_AD       = 3'd4;
    localparam int unsigned CFG_DATA_W = 22;

    // pte bit positions
    localparam int unsigned PTE_V = 0;
    localparam int unsigned PTE_R = 1;
    localparam int unsigned PTE_W = 2;
    localparam int unsigned PTE_X = 3;
    localparam int unsigned PTE_U = 4;
    localparam int unsigned PTE_A = 6;
    localparam int unsigned PTE_D = 7;

    // result queue
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;
    localparam int unsigned QCNT_W      = 3;

    typedef struct packed {
        logic        operation;
        logic [31:0] vaddr;
        logic [1:0]  access_type;
        logic [1:0]  priv;
        logic [31:0] pte_data;
        logic        pte_access_fault;
    } item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [33:0] mem_addr;
        logic [31:0] write_data;
        logic [33:0] phys_addr;
        logic [2:0]  fault_code;
        logic        last_result;
    } result_t;

    typedef struct packed {
        logic        translate_enable;
        logic [21:0] root_table_page;
        logic        allow_user_access;
        logic        exec_implies_read;
        logic        fault_on_ad;
    } cfg_t;

    typedef struct packed {
        logic        busy;
        logic        level;
        logic [31:0] vaddr;
        logic [1:0]  access_type;
        logic [1:0]  priv;
        logic [33:0] entry_address;
    } walk_t;

    // step outputs handed to the result queue
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage : sv32ptw_pkg

`default_nettype wire

// ===== rtl/sv32ptw_step.sv =====
// ----------------------------------------------------------------------------
// sv32ptw_step
// one walk step: checks a request or pte response against the walk state
// ----------------------------------------------------------------------------
`default_nettype none

module sv32ptw_step
    import sv32ptw_pkg::*;
(
    input  item_t item,
    input  walk_t walk,
    input  cfg_t  cfg,
    output push_t push,
    output walk_t walk_next
);

    function automatic result_t make_fault(input logic [2:0] code);
        result_t r;
        r             = '0;
        r.result_kind = KIND_DONE;
        r.fault_code  = code;
        r.last_result = 1'b1;
        return r;
    endfunction

    function automatic result_t make_done(input logic [33:0] pa);
        result_t r;
        r             = '0;
        r.result_kind = KIND_DONE;
        r.phys_addr   = pa;
        r.last_result = 1'b1;
        return r;
    endfunction

    function automatic result_t make_read(input logic [33:0] addr);
        result_t r;
        r             = '0;
        r.result_kind = KIND_READ;
        r.mem_addr    = addr;
        r.last_result = 1'b1;
        return r;
    endfunction

    function automatic result_t make_writeback(input logic [33:0] addr,
                                               input logic [31:0] data);
        result_t r;
        r             = '0;
        r.result_kind = KIND_WRITEBACK;
        r.mem_addr    = addr;
        r.write_data  = data;
        r.last_result = 1'b0;
        return r;
    endfunction

    logic [1:0]  req_type;
    logic [2:0]  req_pf;
    logic [1:0]  ty;
    logic [2:0]  pf;
    logic [2:0]  af;
    logic [33:0] root_addr;
    logic [33:0] next_addr;
    logic [31:0] pte;
    logic [9:0]  vpn0;
    logic [21:0] page;
    logic [33:0] pa;
    logic        fetch_access;
    logic        is_load;
    logic        is_store;
    logic        priv_fault;
    logic        perm_fault;
    logic        need_ad;
    logic [31:0] wb_data;

    // access type 3 counts as a store
    assign req_type = item.access_type[1] ? ACC_STORE : item.access_type;
    assign req_pf   = {1'b0, req_type} + FAULT_PAGE_BASE;
    assign ty       = walk.access_type[1] ? ACC_STORE : walk.access_type;
    assign pf       = {1'b0, ty} + FAULT_PAGE_BASE;
    assign af       = pf + ACCESS_FAULT_OFFSET;
    assign fetch_access = (ty == ACC_FETCH);
    assign is_load  = (ty == ACC_LOAD);
    assign is_store = (ty == ACC_STORE);

    assign pte       = item.pte_data;
    assign vpn0      = walk.vaddr[21:12];
    // page base plus index times four, the low bits never overlap
    assign root_addr = {cfg.root_table_page, item.vaddr[31:22], 2'b00};
    assign next_addr = {pte[31:10], vpn0, 2'b00};

    // superpage keeps vpn0 from the virtual address
    assign page = walk.level ? {pte[31:20], vpn0} : pte[31:10];
    assign pa   = {page, walk.vaddr[11:0]};

    always_comb
    begin
        priv_fault = 1'b0;
        case (walk.priv)
            PRIV_SUPER: priv_fault = pte[PTE_U] && (fetch_access || !cfg.allow_user_access);
            PRIV_USER:  priv_fault = !pte[PTE_U];
            default:    priv_fault = 1'b0;
        endcase
    end

    assign perm_fault = (fetch_access && !pte[PTE_X])
                     || (is_load && !(pte[PTE_R] || (cfg.exec_implies_read && pte[PTE_X])))
                     || (is_store && !pte[PTE_W]);

    assign need_ad = !pte[PTE_A] || (is_store && !pte[PTE_D]);

    always_comb
    begin
        wb_data        = pte;
        wb_data[PTE_A] = 1'b1;
        if (is_store)
        begin
            wb_data[PTE_D] = 1'b1;
        end
    end

    always_comb
    begin
        push      = '0;
        walk_next = walk;
        if (item.operation == OP_TRANSLATE)
        begin
            if (!walk.busy)
            begin
                push.count = 2'd1;
                if (!cfg.translate_enable || item.priv == PRIV_MACHINE)
                begin
                    push.first = make_done({2'b00, item.vaddr});
                end
                else
                begin
                    walk_next.vaddr       = item.vaddr;
                    walk_next.access_type = item.access_type;
                    walk_next.priv        = item.priv;
                    walk_next.level       = 1'b1;
                    if (root_addr == '0)
                    begin
                        walk_next.busy = 1'b0;
                        push.first     = make_fault(req_pf);
                    end
                    else
                    begin
                        walk_next.busy          = 1'b1;
                        walk_next.entry_address = root_addr;
                        push.first              = make_read(root_addr);
                    end
                end
            end
        end
        else if (walk.busy)
        begin
            push.count      = 2'd1;
            walk_next.busy  = 1'b0;
            walk_next.level = 1'b1;
            if (item.pte_access_fault)
            begin
                push.first = make_fault(af);
            end
            else if (!pte[PTE_V] || (pte[PTE_W] && !pte[PTE_R]))
            begin
                push.first = make_fault(pf);
            end
            else if (!(pte[PTE_R] || pte[PTE_X]))
            begin
                // pointer to the next level
                if (pte[PTE_U] || pte[PTE_A] || pte[PTE_D] || !walk.level
                    || next_addr == '0)
                begin
                    push.first = make_fault(pf);
                end
                else
                begin
                    walk_next.busy          = 1'b1;
                    walk_next.level         = 1'b0;
                    walk_next.entry_address = next_addr;
                    push.first              = make_read(next_addr);
                end
            end
            else if (walk.level && pte[19:10] != '0)
            begin
                push.first = make_fault(pf);
            end
            else if (priv_fault || perm_fault || (need_ad && cfg.fault_on_ad))
            begin
                push.first = make_fault(pf);
            end
            else if (need_ad)
            begin
                push.count  = 2'd2;
                push.first  = make_writeback(walk.entry_address, wb_data);
                push.second = make_done(pa);
            end
            else
            begin
                push.first = make_done(pa);
            end
        end
    end

endmodule : sv32ptw_step

`default_nettype wire

// ===== rtl/sv32ptw_queue.sv =====
// ----------------------------------------------------------------------------
// sv32ptw_queue
// small result queue taking up to two results per cycle, one out per cycle unless stalled
// ----------------------------------------------------------------------------
`default_nettype none

module sv32ptw_queue
    import sv32ptw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    room,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result_data
);

    result_t           mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] head_reg;
    logic [QPTR_W-1:0] head_next;
    logic [QPTR_W-1:0] tail_reg;
    logic [QPTR_W-1:0] tail_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              pop;

    assign result_valid = (count_reg != '0);
    assign result_data  = mem[head_reg];
    assign pop          = result_valid && !result_stall;
    // room for a worst case of two results
    assign room         = (count_reg < QCNT_W'(QUEUE_DEPTH - 1));

    assign head_next  = head_reg + QPTR_W'(pop);
    assign tail_next  = tail_reg + QPTR_W'(push.count);
    assign count_next = count_reg + QCNT_W'(push.count) - QCNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[tail_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[tail_reg + QPTR_W'(1)] <= push.second;
        end
    end

endmodule : sv32ptw_queue

`default_nettype wire

// ===== rtl/sv32_page_table_walker.sv =====
// ----------------------------------------------------------------------------
// sv32_page_table_walker
// two-level sv32 translation walker with pte read and a/d write-back results
// ----------------------------------------------------------------------------
// flow: an item lands in the input register on transfer, is stepped into the
//   result queue once the queue has room, and its first result is then offered
// throughput: one item per cycle while the queue has room, set by the single-step
//   input register; an item with a write-back leaves two results for the output
// reset: rst_n asynchronous active low clears the walk state, config and queue
`default_nettype none

module sv32_page_table_walker
    import sv32ptw_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    // request and pte response channel
    input  logic                   item_valid,
    output logic                   item_stall,
    input  item_t                  item_data,

    // result channel
    output logic                   result_valid,
    input  logic                   result_stall,
    output result_t                result_data,

    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // input register
    logic  item_valid_reg;
    logic  item_valid_next;
    item_t item_reg;
    logic  item_take;

    // step control
    logic  room;
    logic  fire;
    push_t step_push;
    push_t push;

    // walk state and configuration
    walk_t walk_reg;
    walk_t walk_next;
    cfg_t  cfg_reg;
    cfg_t  cfg_next;

    // the step fires when the queue can take its worst case of two results
    assign fire       = item_valid_reg && room;
    assign item_stall = item_valid_reg && !room;
    assign item_take  = item_valid && !item_stall;

    assign item_valid_next = item_take || (item_valid_reg && !fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    // payload holds while stalled since no transfer happens then
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            item_reg <= item_data;
        end
    end

    sv32ptw_step u_step (
        .item      (item_reg),
        .walk      (walk_reg),
        .cfg       (cfg_reg),
        .push      (step_push),
        .walk_next (walk_next)
    );

    // nothing enters the queue unless the step fires
    always_comb
    begin
        push = step_push;
        if (!fire)
        begin
            push.count = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_reg.busy          <= 1'b0;
            walk_reg.level         <= 1'b1;
            walk_reg.vaddr         <= '0;
            walk_reg.access_type   <= '0;
            walk_reg.priv          <= '0;
            walk_reg.entry_address <= '0;
        end
        else if (fire)
        begin
            walk_reg <= walk_next;
        end
    end

    // configuration writes, always ready
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TRANSLATE_ENABLE:  cfg_next.translate_enable  = cfg_data[0];
                CFG_ROOT_TABLE_PAGE:   cfg_next.root_table_page   = cfg_data;
                CFG_ALLOW_USER_ACCESS: cfg_next.allow_user_access = cfg_data[0];
                CFG_EXEC_IMPLIES_READ: cfg_next.exec_implies_read = cfg_data[0];
                CFG_FAULT_ON_AD:       cfg_next.fault_on_ad       = cfg_data[0];
                default:               cfg_next                   = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sv32ptw_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room         (room),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    // two results only come from a response that completes a walk by write-back
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2) |->
            (item_reg.operation == OP_RESPONSE && walk_reg.busy && !cfg_reg.fault_on_ad))
    else $error("write-back pair outside a completing walk");

    // a write-back pair is write-back then finished, last marked only on the second
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2) |->
            (push.first.result_kind == KIND_WRITEBACK && !push.first.last_result
             && push.second.result_kind == KIND_DONE && push.second.last_result))
    else $error("malformed write-back pair");

    // a pte read request leaves the walker busy waiting for its response
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd1 && push.first.result_kind == KIND_READ) |=> walk_reg.busy)
    else $error("pte read issued without a walk in progress");

endmodule : sv32_page_table_walker

`default_nettype wire
